FILE: src/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg: shared definitions for the RGB blend-mode compositor
// Channel and register widths, register indexes, blend mode codes, the
// reciprocal used to divide by 255 and the pipeline load-enable bundle.
// ----------------------------------------------------------------------------
package rbc_pkg;

	// Field widths.
	localparam int CH_W       = 8;
	localparam int MODE_W     = 3;
	localparam int OPA_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 2'd1;

	// Register reset values.
	localparam logic [OPA_W-1:0] OPACITY_FULL = 9'd256;

	// Division by 255 as a multiplication by ceil(2^25 / 255) and a shift.
	// It is exact for every dividend below 2^17.
	localparam int                 RECIP_SHIFT = 25;
	localparam logic [17:0]        RECIP_255   = 18'd131587;
	localparam logic [16:0]        CEIL_BIAS   = 17'd254;
	localparam logic [CH_W-1:0]    CH_MAX      = 8'd255;

	// Blend mode codes. Codes with no member behave as normal.
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD      = 3'd0,
		MODE_MULTIPLY = 3'd1,
		MODE_SCREEN   = 3'd2,
		MODE_OVERLAY  = 3'd3,
		MODE_NORMAL   = 3'd4
	} blend_mode_t;

	// Load enables for the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

FILE: src/rbc_channel.sv
// ----------------------------------------------------------------------------
// rbc_channel: four-stage datapath for one colour channel
// Stage 1 forms the blend product, stage 2 divides it by 255, stage 3 scales
// the difference to the base by the opacity, stage 4 adds and clamps.
// ----------------------------------------------------------------------------
module rbc_channel (
	input  logic                          clk,
	input  rbc_pkg::stage_en_t            en,
	input  logic [rbc_pkg::MODE_W-1:0]    blend_mode,
	input  logic [rbc_pkg::OPA_W-1:0]     opacity,
	input  logic [rbc_pkg::CH_W-1:0]      base,
	input  logic [rbc_pkg::CH_W-1:0]      top,
	output logic [rbc_pkg::CH_W-1:0]      result
);
	import rbc_pkg::*;

	// Stage 1 registers.
	logic [15:0]     prod_s1;
	logic            inv_s1;
	logic            dbl_s1;
	logic            use_prod_s1;
	logic [CH_W-1:0] direct_s1;
	logic [CH_W-1:0] base_s1;

	// Stage 2 registers.
	logic [CH_W-1:0] quot_s2;
	logic            inv_s2;
	logic            use_prod_s2;
	logic [CH_W-1:0] direct_s2;
	logic [CH_W-1:0] base_s2;

	// Stage 3 registers.
	logic signed [18:0] mix_s3;
	logic [CH_W-1:0]    base_s3;

	// Stage 4 register.
	logic [CH_W-1:0] out_s4;

	// Stage 1: pick the operands of the one product the mode needs.
	logic            inv_c;
	logic            dbl_c;
	logic            use_prod_c;
	logic [CH_W-1:0] direct_c;
	logic [CH_W:0]   sum_c;
	logic [CH_W-1:0] op_x_c;
	logic [CH_W-1:0] op_y_c;

	always_comb begin
		sum_c      = {1'b0, base} + {1'b0, top};
		inv_c      = 1'b0;
		dbl_c      = 1'b0;
		use_prod_c = 1'b0;
		direct_c   = top;
		case (blend_mode)
			MODE_ADD: begin
				direct_c = sum_c[CH_W] ? CH_MAX : sum_c[CH_W-1:0];
			end
			MODE_MULTIPLY: begin
				use_prod_c = 1'b1;
			end
			MODE_SCREEN: begin
				use_prod_c = 1'b1;
				inv_c      = 1'b1;
			end
			MODE_OVERLAY: begin
				use_prod_c = 1'b1;
				dbl_c      = 1'b1;
				inv_c      = base[CH_W-1];
			end
			default: begin
				direct_c = top;
			end
		endcase
		// 255 - v is the bitwise complement for an 8-bit value.
		op_x_c = inv_c ? ~base : base;
		op_y_c = inv_c ? ~top : top;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1     <= {8'd0, op_x_c} * {8'd0, op_y_c};
			inv_s1      <= inv_c;
			dbl_s1      <= dbl_c;
			use_prod_s1 <= use_prod_c;
			direct_s1   <= direct_c;
			base_s1     <= base;
		end
	end

	// Stage 2: floor or ceiling of the (possibly doubled) product over 255.
	logic [16:0] num_c;
	logic [16:0] num_bias_c;
	logic [34:0] recip_prod_c;

	always_comb begin
		num_c        = dbl_s1 ? {prod_s1, 1'b0} : {1'b0, prod_s1};
		num_bias_c   = num_c + (inv_s1 ? CEIL_BIAS : 17'd0);
		recip_prod_c = {18'd0, num_bias_c} * {17'd0, RECIP_255};
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			quot_s2     <= recip_prod_c[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
			inv_s2      <= inv_s1;
			use_prod_s2 <= use_prod_s1;
			direct_s2   <= direct_s1;
			base_s2     <= base_s1;
		end
	end

	// Stage 3: blend value, difference to the base, scaled by the opacity.
	logic [CH_W-1:0]    blend_c;
	logic signed [8:0]  diff_c;
	logic signed [18:0] mix_c;

	always_comb begin
		if (use_prod_s2) begin
			blend_c = inv_s2 ? ~quot_s2 : quot_s2;
		end else begin
			blend_c = direct_s2;
		end
		diff_c = $signed({1'b0, blend_c}) - $signed({1'b0, base_s2});
		mix_c  = 19'(diff_c) * 19'($signed({1'b0, opacity}));
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			mix_s3  <= mix_c;
			base_s3 <= base_s2;
		end
	end

	// Stage 4: floor divide by 256, add to the base and clamp to 0..255.
	logic signed [10:0] step_c;
	logic signed [11:0] total_c;
	logic [CH_W-1:0]    clamp_c;

	always_comb begin
		step_c  = 11'(mix_s3 >>> 8);
		total_c = $signed({4'd0, base_s3}) + 12'(step_c);
		if (total_c < 0) begin
			clamp_c = '0;
		end else if (total_c > $signed({4'd0, CH_MAX})) begin
			clamp_c = CH_MAX;
		end else begin
			clamp_c = total_c[CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			out_s4 <= clamp_c;
		end
	end

	assign result = out_s4;

endmodule

FILE: src/rgb_blend_mode_composite_unit.sv
// ----------------------------------------------------------------------------
// rgb_blend_mode_composite_unit: RGB888 blend-mode compositor with opacity
// Blends a foreground pixel over a base pixel per channel and mixes the
// blend back towards the base by a programmable opacity.
// ----------------------------------------------------------------------------
// The unit takes one pixel pair per clock while the output side does not
// stall, since every stage can load on every cycle. A pixel passes through
// the stage registers s1, s2, s3 and s4 in order and is then presented at
// the output. The four stages are the
// blend product, the division by 255, the opacity multiply and the final add
// with clamp; each of the first three holds one of the multipliers.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so empty slots are squeezed out during an output stall and
// the input stays ready unless all four stages hold a pixel and the output is
// stalled. The configuration
// port always accepts; write blend_mode and opacity only while no pixel is in
// flight. Register index 0 is blend_mode (0 add, 1 multiply, 2 screen,
// 3 overlay, 4 to 7 normal), index 1 is opacity (256 is full strength, larger
// values extrapolate); writes to other indexes are ignored.
// ----------------------------------------------------------------------------
module rgb_blend_mode_composite_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Pixel input channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rbc_pkg::CH_W-1:0]          base_red,
	input  logic [rbc_pkg::CH_W-1:0]          base_green,
	input  logic [rbc_pkg::CH_W-1:0]          base_blue,
	input  logic [rbc_pkg::CH_W-1:0]          top_red,
	input  logic [rbc_pkg::CH_W-1:0]          top_green,
	input  logic [rbc_pkg::CH_W-1:0]          top_blue,
	// Pixel output channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rbc_pkg::CH_W-1:0]          out_red,
	output logic [rbc_pkg::CH_W-1:0]          out_green,
	output logic [rbc_pkg::CH_W-1:0]          out_blue
);
	import rbc_pkg::*;

	logic [MODE_W-1:0] blend_mode_q;
	logic [OPA_W-1:0]  opacity_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	stage_en_t en;

	// Configuration registers; every write transfer is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_ADD;
			opacity_q    <= OPACITY_FULL;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BLEND_MODE) begin
				blend_mode_q <= cfg_data[MODE_W-1:0];
			end else if (cfg_index == REG_OPACITY) begin
				opacity_q <= cfg_data[OPA_W-1:0];
			end
		end
	end

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		en.s4 = !valid_s4 || out_ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = valid_s4;

	// Valid bits travel alongside the channel data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= in_valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// One datapath per colour channel.
	rbc_channel u_red (
		.clk        (clk),
		.en         (en),
		.blend_mode (blend_mode_q),
		.opacity    (opacity_q),
		.base       (base_red),
		.top        (top_red),
		.result     (out_red)
	);

	rbc_channel u_green (
		.clk        (clk),
		.en         (en),
		.blend_mode (blend_mode_q),
		.opacity    (opacity_q),
		.base       (base_green),
		.top        (top_green),
		.result     (out_green)
	);

	rbc_channel u_blue (
		.clk        (clk),
		.en         (en),
		.blend_mode (blend_mode_q),
		.opacity    (opacity_q),
		.base       (base_blue),
		.top        (top_blue),
		.result     (out_blue)
	);

	// An empty output stage always leaves room for a new input transfer.
	a_room_when_out_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready although the output stage is empty");

	// With all stages full and the output stalled, no input may be taken.
	a_full_blocks_input : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !out_ready) |-> !in_ready)
		else $error("input taken while the pipeline is full and stalled");

	// An input transfer without an output transfer adds one pixel in flight.
	a_occupancy_grows : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(out_valid && out_ready)) |=>
		($countones({valid_s1, valid_s2, valid_s3, valid_s4}) ==
		 $past($countones({valid_s1, valid_s2, valid_s3, valid_s4})) + 1))
		else $error("pixel lost or duplicated on input transfer");

	// An output transfer without an input transfer removes one pixel.
	a_occupancy_shrinks : assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && out_valid && out_ready) |=>
		($countones({valid_s1, valid_s2, valid_s3, valid_s4}) + 1 ==
		 $past($countones({valid_s1, valid_s2, valid_s3, valid_s4}))))
		else $error("pixel lost or duplicated on output transfer");

endmodule
